// ----- rtl/core/mtsa_pkg.sv -----
`timescale 1ns / 1ps
// types, constants and helper functions for the macro tiled surface address unit
// no dependencies

package mtsa_pkg;

  localparam int unsigned NUM_BANKS  = 4;
  localparam int unsigned NUM_PIPES  = 2;
  localparam int unsigned PIPE_W     = 1;
  localparam int unsigned BANK_W     = 2;
  localparam int unsigned GROUP_BITS = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [7:0] BPE_8   = 8'd8;
  localparam logic [7:0] BPE_16  = 8'd16;
  localparam logic [7:0] BPE_64  = 8'd64;
  localparam logic [7:0] BPE_128 = 8'd128;

  localparam logic [2:0] ASPECT_2 = 3'd2;
  localparam logic [2:0] ASPECT_4 = 3'd4;

  localparam logic [7:0]  RST_BPE       = 8'd32;
  localparam logic        RST_DEPTH     = 1'b0;
  localparam logic [2:0]  RST_ASPECT    = 3'd1;
  localparam logic [13:0] RST_PITCH     = 14'd0;
  localparam logic        RST_PIPE_SWZ  = 1'b0;
  localparam logic [2:0]  RST_BANK_SWZ  = 3'd0;
  localparam logic [14:0] RST_SWAP_W    = 15'd0;

  localparam logic [2:0] SWAP_SEQ [8] = '{3'd0, 3'd1, 3'd3, 3'd2, 3'd6, 3'd7, 3'd5, 3'd4};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPE      = 3'd0,
    CFG_DEPTH    = 3'd1,
    CFG_ASPECT   = 3'd2,
    CFG_PITCH    = 3'd3,
    CFG_PIPE_SWZ = 3'd4,
    CFG_BANK_SWZ = 3'd5,
    CFG_SWAP_W   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  bpe;
    logic        depth;
    logic [2:0]  aspect;
    logic [13:0] pitch;
    logic        pipe_swz;
    logic [2:0]  bank_swz;
    logic [14:0] swap_width;
  } cfg_t;

  typedef struct packed {
    logic [12:0] coord_x;
    logic [12:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic [31:0] byte_address;
    logic [1:0]  bank_used;
    logic        pipe_used;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic [10:0] elem;
    logic [25:0] scaled;
    logic [2:0]  bp;
    logic        swap_en;
  } path_out_t;

  // log2 of macro tile width in elements: 5, 4 or 3
  function automatic logic [2:0] pitch_log2(logic [2:0] aspect);
    logic [2:0] res;
    res = 3'd5;
    if (aspect == ASPECT_2) res = 3'd4;
    if (aspect == ASPECT_4) res = 3'd3;
    return res;
  endfunction

  // pixel index inside the 8x8 micro tile
  function automatic logic [5:0] micro_index(logic [2:0] x, logic [2:0] y, logic depth,
                                             logic [7:0] bpe);
    logic [5:0] idx;
    priority if (depth) begin
      idx = {y[2], x[2], y[1], x[1], y[0], x[0]};
    end else if (bpe == BPE_8) begin
      idx = {y[2], y[0], y[1], x[2], x[1], x[0]};
    end else if (bpe == BPE_16) begin
      idx = {y[2], y[1], y[0], x[2], x[1], x[0]};
    end else if (bpe == BPE_64) begin
      idx = {y[2], y[1], x[2], x[1], y[0], x[0]};
    end else if (bpe == BPE_128) begin
      idx = {y[2], y[1], x[2], x[1], x[0], y[0]};
    end else begin
      idx = {y[2], y[1], x[2], y[0], x[1], x[0]};
    end
    return idx;
  endfunction

endpackage

// ----- rtl/core/mtsa_cfg_regs.sv -----
`timescale 1ns / 1ps
// configuration register file of the macro tiled surface address unit
// depends on mtsa_pkg

module mtsa_cfg_regs import mtsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpe        <= RST_BPE;
      cfg_q.depth      <= RST_DEPTH;
      cfg_q.aspect     <= RST_ASPECT;
      cfg_q.pitch      <= RST_PITCH;
      cfg_q.pipe_swz   <= RST_PIPE_SWZ;
      cfg_q.bank_swz   <= RST_BANK_SWZ;
      cfg_q.swap_width <= RST_SWAP_W;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BPE:      cfg_q.bpe        <= cfg_data_i[7:0];
        CFG_DEPTH:    cfg_q.depth      <= cfg_data_i[0];
        CFG_ASPECT:   cfg_q.aspect     <= cfg_data_i[2:0];
        CFG_PITCH:    cfg_q.pitch      <= cfg_data_i[13:0];
        CFG_PIPE_SWZ: cfg_q.pipe_swz   <= cfg_data_i[0];
        CFG_BANK_SWZ: cfg_q.bank_swz   <= cfg_data_i[2:0];
        CFG_SWAP_W:   cfg_q.swap_width <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/mtsa_swap_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider giving the low bank swap index bits
// depends on mtsa_pkg

module mtsa_swap_div import mtsa_pkg::*; (
  input  logic        clk_i,
  input  logic [12:0] x_i,
  input  logic [2:0]  aspect_i,
  input  logic [14:0] width_i,
  output logic [1:0]  quo_o
);

  localparam int unsigned DEN_W = 15;

  function automatic logic [DEN_W:0] div_step(logic [DEN_W-1:0] r, logic nb,
                                              logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    logic [DEN_W:0] res;
    t = {r, nb};
    if (t >= {1'b0, d}) begin
      t   = t - {1'b0, d};
      res = {1'b1, t[DEN_W-1:0]};
    end else begin
      res = {1'b0, t[DEN_W-1:0]};
    end
    return res;
  endfunction

  logic [12:0]      num1_q;
  logic [DEN_W-1:0] den1_q;
  logic [8:0]       num2_q;
  logic [DEN_W-1:0] den2_q, rem2_q, rem2_d;
  logic [4:0]       num3_q;
  logic [DEN_W-1:0] den3_q, rem3_q, rem3_d;
  logic [1:0]       quo_q, quo_d;
  logic [12:0]      shifted;
  logic [2:0]       ps;

  assign ps      = pitch_log2(aspect_i);
  assign shifted = x_i >> ps;

  always_comb begin
    logic [DEN_W:0] s;
    rem2_d = '0;
    for (int i = 0; i < 4; i++) begin
      s      = div_step(rem2_d, num1_q[12-i], den1_q);
      rem2_d = s[DEN_W-1:0];
    end
  end

  always_comb begin
    logic [DEN_W:0] s;
    rem3_d = rem2_q;
    for (int i = 0; i < 4; i++) begin
      s      = div_step(rem3_d, num2_q[8-i], den2_q);
      rem3_d = s[DEN_W-1:0];
    end
  end

  always_comb begin
    logic [DEN_W:0]   s;
    logic [DEN_W-1:0] r;
    r     = rem3_q;
    quo_d = '0;
    for (int i = 0; i < 5; i++) begin
      s     = div_step(r, num3_q[4-i], den3_q);
      r     = s[DEN_W-1:0];
      quo_d = {quo_d[0], s[DEN_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    num1_q <= shifted << ps;
    den1_q <= width_i;
    num2_q <= num1_q[8:0];
    den2_q <= den1_q;
    rem2_q <= rem2_d;
    num3_q <= num2_q[4:0];
    den3_q <= den2_q;
    rem3_q <= rem3_d;
    quo_q  <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// ----- rtl/core/mtsa_addr_path.sv -----
`timescale 1ns / 1ps
// four stage datapath: tile coordinates, micro tile offset and macro tile offset
// depends on mtsa_pkg

module mtsa_addr_path import mtsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_word_t  in_i,
  input  cfg_t      cfg_i,
  output path_out_t path_o
);

  logic [2:0]  ps, hs;
  logic [12:0] x_sh, y_sh;
  logic [13:0] p_sh;
  logic [2:0]  bp_raw;

  logic [3:0]  v_q;

  logic [5:0]  idx1_q;
  logic [9:0]  mtx1_q;
  logic [8:0]  mty1_q;
  logic [10:0] tpr1_q;
  logic [2:0]  bp1_q;
  logic        swap1_q;

  logic [13:0] elem_full;
  logic [10:0] elem2_q;
  logic [19:0] prod2_q;
  logic [9:0]  mtx2_q;
  logic [2:0]  bp2_q;
  logic        swap2_q;

  logic [10:0] elem3_q;
  logic [20:0] sum3_q;
  logic [2:0]  bp3_q;
  logic        swap3_q;

  logic [10:0] elem4_q;
  logic [25:0] scaled4_q;
  logic [2:0]  bp4_q;
  logic        swap4_q;

  assign ps   = pitch_log2(cfg_i.aspect);
  assign hs   = 3'd1 - ps + 3'd4 + 3'd4;
  assign x_sh = in_i.coord_x >> ps;
  assign y_sh = in_i.coord_y >> hs;
  assign p_sh = cfg_i.pitch >> ps;

  assign bp_raw = {in_i.coord_y[4] ^ in_i.coord_x[4],
                   in_i.coord_y[5] ^ in_i.coord_x[3],
                   in_i.coord_y[3] ^ in_i.coord_x[3]};

  assign elem_full = {6'b0, cfg_i.bpe} * {8'b0, idx1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      idx1_q  <= micro_index(in_i.coord_x[2:0], in_i.coord_y[2:0], cfg_i.depth, cfg_i.bpe);
      mtx1_q  <= x_sh[9:0];
      mty1_q  <= y_sh[8:0];
      tpr1_q  <= p_sh[10:0];
      bp1_q   <= bp_raw ^ {cfg_i.bank_swz[1:0], cfg_i.pipe_swz};
      swap1_q <= (cfg_i.swap_width != '0);
    end
    if (v_q[0]) begin
      elem2_q <= elem_full[13:3];
      prod2_q <= {9'b0, tpr1_q} * {11'b0, mty1_q};
      mtx2_q  <= mtx1_q;
      bp2_q   <= bp1_q;
      swap2_q <= swap1_q;
    end
    if (v_q[1]) begin
      elem3_q <= elem2_q;
      sum3_q  <= {11'b0, mtx2_q} + {1'b0, prod2_q};
      bp3_q   <= bp2_q;
      swap3_q <= swap2_q;
    end
    if (v_q[2]) begin
      elem4_q   <= elem3_q;
      scaled4_q <= {18'b0, cfg_i.bpe} * {5'b0, sum3_q};
      bp4_q     <= bp3_q;
      swap4_q   <= swap3_q;
    end
  end

  assign path_o.valid   = v_q[3];
  assign path_o.elem    = elem4_q;
  assign path_o.scaled  = scaled4_q;
  assign path_o.bp      = bp4_q;
  assign path_o.swap_en = swap4_q;

endmodule

// ----- rtl/core/macro_tiled_surface_address_unit.sv -----
`timescale 1ns / 1ps
// top level of the macro tiled surface address unit: final bank swap and address splice
// depends on mtsa_pkg, mtsa_cfg_regs, mtsa_addr_path, mtsa_swap_div
//
//   channel   handshake              word
//   input     start, busy            coord_i    (in_word_t)
//   result    res_valid_o (strobe)   res_o      (out_word_t)
//   config    cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//
// one word enters per cycle; its result is shown for one cycle
// the pipeline has five register stages: tile coordinates, products,
// tile sum, size scaling and bank swap divider, address splice
// busy stays low; reset clears the valid bits only, no clearing pass
// the receiver cannot stall, so the pipeline never holds

module macro_tiled_surface_address_unit import mtsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              coord_i,
  output logic                  res_valid_o,
  output out_word_t             res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg;
  path_out_t path;
  logic      accept;
  logic [1:0]  quo;
  logic [1:0]  bank_f;
  logic [2:0]  seq;
  logic [28:0] total;
  logic        res_valid_q;
  out_word_t   res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mtsa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mtsa_addr_path u_path (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_i       (coord_i),
    .cfg_i      (cfg),
    .path_o     (path)
  );

  mtsa_swap_div u_div (
    .clk_i    (clk_i),
    .x_i      (coord_i.coord_x),
    .aspect_i (cfg.aspect),
    .width_i  (cfg.swap_width),
    .quo_o    (quo)
  );

  assign seq    = SWAP_SEQ[{1'b0, quo}];
  assign bank_f = path.bp[2:1] ^ (path.swap_en ? seq[1:0] : 2'b00);
  assign total  = {18'b0, path.elem} + {path.scaled, 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= path.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (path.valid) begin
      res_q.byte_address <= {total[28:8], bank_f, path.bp[0], total[7:0]};
      res_q.bank_used    <= bank_f;
      res_q.pipe_used    <= path.bp[0];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, 5))
    else $error("result without a word accepted five cycles earlier");

  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.pipe_used ==
      $past(coord_i.coord_x[3] ^ coord_i.coord_y[3] ^ cfg.pipe_swz, 5))
    else $error("pipe bit does not follow the coordinate");

  a_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(cfg.swap_width == '0, 5) |-> res_o.bank_used ==
      $past({coord_i.coord_y[4] ^ coord_i.coord_x[4],
             coord_i.coord_y[5] ^ coord_i.coord_x[3]} ^ cfg.bank_swz[1:0], 5))
    else $error("unswapped bank does not follow the coordinate");

endmodule
